### rtl/ssd_pkg.sv
package ssd_pkg;

   // item payload width
   localparam int DATA_W = 32;

   // default number of distinct values the seen store holds
   localparam int STORE_DEPTH_DEF = 128;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // take a new item and restart the scan
      logic scan;    // issue the next store read and compare
      logic commit;  // record the value if the store has room and present it as a result
   } ssd_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic done;      // scan finished, nothing left in flight
      logic hit;       // value already in the seen store
      logic out_free;  // result register can take a new item
   } ssd_status_type;

endpackage

### rtl/ssd_ctrl.sv
module ssd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssd_pkg::ssd_status_type status,
   output ssd_pkg::ssd_cmd_type    cmd
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ready_in   = ready_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
               ready_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.done) begin
               if (status.hit) begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end else if (status.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
                  ready_in   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

### rtl/ssd_datapath.sv
module ssd_datapath #(
   parameter int STORE_DEPTH = ssd_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [ssd_pkg::DATA_W-1:0] req_value,
   input  logic                              req_start_of_list,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ssd_pkg::DATA_W-1:0] rsp_unique_value,
   output logic                              rsp_overflow,
   input  ssd_pkg::ssd_cmd_type               cmd,
   output ssd_pkg::ssd_status_type            status
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

   logic [ssd_pkg::DATA_W-1:0] seen_mem [STORE_DEPTH];

   logic [ssd_pkg::DATA_W-1:0] val_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic [ssd_pkg::DATA_W-1:0] rd_data_ff;
   logic                       rd_valid_ff, rd_valid_in;
   logic                       match_ff, match_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ssd_pkg::DATA_W-1:0] rsp_value_ff;
   logic                       rsp_ovf_ff;
   logic                       issue;
   logic                       store_full;

   // a read goes out while entries remain and no hit has been seen
   assign issue      = cmd.scan && (scan_ff != count_ff) && !match_ff;
   assign store_full = (count_ff == DEPTH_CNT);

   // scan control and store fill count
   always_comb begin
      count_in    = count_ff;
      scan_in     = scan_ff;
      match_in    = match_ff;
      rd_valid_in = 1'b0;
      if (cmd.load) begin
         if (req_start_of_list) begin
            count_in = '0;
         end
         scan_in  = '0;
         match_in = 1'b0;
      end else begin
         if (rd_valid_ff && (rd_data_ff == val_ff)) begin
            match_in = 1'b1;
         end
         if (issue) begin
            scan_in     = scan_ff + 1'b1;
            rd_valid_in = 1'b1;
         end
         if (cmd.commit && !store_full) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         match_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         match_ff     <= match_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item value and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_value;
      end
      if (cmd.commit) begin
         rsp_value_ff <= val_ff;
         rsp_ovf_ff   <= store_full;
      end
   end

   // seen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && !store_full) begin
         seen_mem[count_ff[ADDR_W-1:0]] <= val_ff;
      end
      if (issue) begin
         rd_data_ff <= seen_mem[scan_ff[ADDR_W-1:0]];
      end
   end

   assign status.done     = !rd_valid_ff && ((scan_ff == count_ff) || match_ff);
   assign status.hit      = match_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_unique_value = $signed(rsp_value_ff);
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

### rtl/stream_stable_deduplicator.sv
// result: a new value is loaded, compared in turn with each seen value of the current
//   list through the registered read port, and then committed; a repeat gives no result
// flow: one item at a time; the next item is accepted only after the scan ends, which a
//   repeat ends early at its matching entry, and after a new value has been committed;
//   a result held by rsp_ready stalls that commit and so the next accept
// reset: synchronous; clears the fill count, scan and result valid, store contents untouched
module stream_stable_deduplicator #(
   parameter int STORE_DEPTH = ssd_pkg::STORE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [ssd_pkg::DATA_W-1:0] req_value,
   input  logic                              req_start_of_list,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ssd_pkg::DATA_W-1:0] rsp_unique_value,
   output logic                              rsp_overflow
);

   ssd_pkg::ssd_cmd_type    cmd;
   ssd_pkg::ssd_status_type status;

   // sequencer
   ssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // seen store, compare and result register
   ssd_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .req_start_of_list (req_start_of_list),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_unique_value  (rsp_unique_value),
      .rsp_overflow      (rsp_overflow),
      .cmd               (cmd),
      .status            (status)
   );

   // only one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // a result is only written into a free result register
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result register overwritten");

   // a result only after a finished scan without a hit
   a_commit_new: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (status.done && !status.hit))
      else $error("duplicate or unfinished item emitted");

endmodule
